// ===== src/hdpm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Holonomic drive power mixer package
// Register map, register file type and output limits shared by the design.
// ----------------------------------------------------------------------------
package hdpm_pkg;

    localparam int APB_AW = 4;

    localparam logic [APB_AW-1:0] ADDR_DIST_GAIN = 4'h0;
    localparam logic [APB_AW-1:0] ADDR_ANG_GAIN  = 4'h4;
    localparam logic [APB_AW-1:0] ADDR_MIN_DRIVE = 4'h8;

    localparam logic [15:0] RST_DIST_GAIN = 16'd6400;
    localparam logic [15:0] RST_ANG_GAIN  = 16'd12800;
    localparam logic [6:0]  RST_MIN_DRIVE = 7'd30;

    localparam int OUT_MAX = 127;

    typedef struct packed {
        logic [15:0] dist_gain;
        logic [15:0] ang_gain;
        logic [6:0]  min_drive;
    } t_cfg;

endpackage
`default_nettype wire

// ===== src/hdpm_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, several dividends sharing one divisor, with a
// sideband word that travels alongside. The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module hdpm_div #(
    parameter int NL = 1,
    parameter int DW = 8,
    parameter int VW = 8,
    parameter int QW = 8,
    parameter int SW = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [NL-1:0][DW-1:0]  i_num,
    input  logic [VW-1:0]          i_den,
    input  logic [SW-1:0]          i_side,
    output logic                   o_valid,
    output logic [NL-1:0][QW-1:0]  o_quo,
    output logic [SW-1:0]          o_side
);

    localparam int RW = (DW > VW + QW) ? DW : VW + QW;

    logic [NL-1:0][RW-1:0] r_rem  [QW];
    logic [NL-1:0][QW-1:0] r_quo  [QW];
    logic [VW-1:0]         r_den  [QW];
    logic [SW-1:0]         r_side [QW];
    logic                  r_vld  [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [NL-1:0][RW-1:0] c_rem;
        logic [NL-1:0][QW-1:0] c_quo;
        logic [VW-1:0]         c_den;
        logic [SW-1:0]         c_side;
        logic                  c_vld;
        logic [RW-1:0]         c_trial;
        logic [NL-1:0][RW-1:0] n_rem;
        logic [NL-1:0][QW-1:0] n_quo;

        if (g == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < NL; l++) begin
                    c_rem[l] = RW'(i_num[l]);
                end
                c_quo  = '0;
                c_den  = i_den;
                c_side = i_side;
                c_vld  = i_valid;
            end
        end else begin : g_next
            assign c_rem  = r_rem[g-1];
            assign c_quo  = r_quo[g-1];
            assign c_den  = r_den[g-1];
            assign c_side = r_side[g-1];
            assign c_vld  = r_vld[g-1];
        end

        assign c_trial = RW'(c_den) << (QW - 1 - g);

        always_comb begin
            for (int l = 0; l < NL; l++) begin
                if (c_rem[l] >= c_trial) begin
                    n_rem[l] = c_rem[l] - c_trial;
                    n_quo[l] = c_quo[l] | (QW'(1) << (QW - 1 - g));
                end else begin
                    n_rem[l] = c_rem[l];
                    n_quo[l] = c_quo[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= c_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_quo[g]  <= n_quo;
                r_den[g]  <= c_den;
                r_side[g] <= c_side;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule
`default_nettype wire

// ===== src/holonomic_drive_power_mixer.sv =====
`default_nettype none
// Throughput: one item per cycle unless the output stalls; the three pipelined
// dividers set most of the depth.
// The whole pipeline advances together whenever the output register is empty or taken.
// Reset (synchronous, active low) clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// Holonomic drive power mixer
// Turns x, y, heading and distance errors into four X-drive wheel powers.
// ----------------------------------------------------------------------------
module holonomic_drive_power_mixer #(
    parameter int POWER_LIMIT = 127
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: x_error[23:0], y_error[47:24], heading_error[63:48],
    //        remaining_distance[87:64]
    input  logic [87:0] s_axis_tdata,
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: left_front_power[7:0], left_back_power[15:8],
    //        right_front_power[23:16], right_back_power[31:24]
    output logic [31:0] m_axis_tdata,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hdpm_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    import hdpm_pkg::*;

    // Width of the base power (Q.16), of the angle magnitude and of the
    // wheel magnitudes before any rescaling.
    localparam int PB = $clog2(POWER_LIMIT + 1);
    localparam int BW = PB + 16;
    localparam int AW = 27;
    localparam int MW = ((BW > AW) ? BW : AW) + 1;
    localparam int WW = MW + 1;
    localparam int QU = (PB < 7) ? 7 : PB;
    localparam int DN = MW + BW;
    localparam int UN = BW + 7;
    localparam int CW = (BW > 23) ? BW : 23;
    localparam logic [BW-1:0] LIMIT = BW'(POWER_LIMIT) << 16;

    typedef struct packed {
        logic          x_neg;
        logic          x_zero;
        logic          y_neg;
        logic          y_zero;
        logic          x_gt_y;
        logic          ax_gt_ay;
        logic          both_zero;
        logic          ang_neg;
        logic [AW-1:0] ang_mag;
        logic [BW-1:0] base;
    } t_mix;

    typedef struct packed {
        logic [3:0]    neg;
        logic [BW-1:0] mprime;
    } t_dn_side;

    function automatic logic signed [WW-1:0] apply_sign(logic neg, logic zero,
                                                        logic [MW-1:0] mag);
        logic signed [WW-1:0] v;
        v = $signed({1'b0, mag});
        if (zero) begin
            return '0;
        end else if (neg) begin
            return -v;
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers. Writes complete in the access cycle.
    // ------------------------------------------------------------------
    t_cfg r_cfg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dist_gain <= RST_DIST_GAIN;
            r_cfg.ang_gain  <= RST_ANG_GAIN;
            r_cfg.min_drive <= RST_MIN_DRIVE;
        end else if (cfg_wr) begin
            case (paddr)
                ADDR_DIST_GAIN: r_cfg.dist_gain <= pwdata[15:0];
                ADDR_ANG_GAIN:  r_cfg.ang_gain  <= pwdata[15:0];
                ADDR_MIN_DRIVE: r_cfg.min_drive <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_DIST_GAIN: prdata = {16'd0, r_cfg.dist_gain};
            ADDR_ANG_GAIN:  prdata = {16'd0, r_cfg.ang_gain};
            ADDR_MIN_DRIVE: prdata = {25'd0, r_cfg.min_drive};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // One enable moves every stage; the pipeline stalls only when the
    // output register holds an item that is not being taken.
    // ------------------------------------------------------------------
    logic en;
    logic r_out_vld;
    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;

    // ------------------------------------------------------------------
    // Stage 1: base power, heading term, error magnitudes and signs.
    // ------------------------------------------------------------------
    logic signed [23:0] in_x, in_y;
    logic signed [15:0] in_h;
    logic [23:0]        in_d;
    logic [39:0]        n_base_prod;
    logic signed [32:0] n_ang_prod;
    logic [32:0]        n_ang_abs;
    logic [23:0]        n_ax, n_ay, n_small, n_large;
    t_mix               n_mix, r_mix;
    logic               r_s1_vld;
    logic [39:0]        r_rat_num;
    logic [23:0]        r_rat_den;

    assign in_x = s_axis_tdata[23:0];
    assign in_y = s_axis_tdata[47:24];
    assign in_h = s_axis_tdata[63:48];
    assign in_d = s_axis_tdata[87:64];

    always_comb begin
        n_base_prod = r_cfg.dist_gain * in_d;
        n_ang_prod  = in_h * $signed({1'b0, r_cfg.ang_gain});
        n_ang_abs   = n_ang_prod[32] ? 33'(-n_ang_prod) : 33'(n_ang_prod);
        n_ax        = in_x[23] ? 24'(-in_x) : 24'(in_x);
        n_ay        = in_y[23] ? 24'(-in_y) : 24'(in_y);
        n_small     = (n_ax < n_ay) ? n_ax : n_ay;
        n_large     = (n_ax < n_ay) ? n_ay : n_ax;

        n_mix.x_neg     = in_x[23];
        n_mix.x_zero    = (in_x == '0);
        n_mix.y_neg     = in_y[23];
        n_mix.y_zero    = (in_y == '0);
        n_mix.x_gt_y    = (in_x > in_y);
        n_mix.ax_gt_ay  = (n_ax > n_ay);
        n_mix.both_zero = (n_large == '0);
        n_mix.ang_neg   = n_ang_prod[32];
        n_mix.ang_mag   = n_ang_abs[AW+3:4];
        n_mix.base      = (n_base_prod > 40'(LIMIT)) ? LIMIT : n_base_prod[BW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mix     <= n_mix;
            r_rat_num <= {n_small, 16'd0};
            r_rat_den <= n_mix.both_zero ? 24'd1 : n_large;
        end
    end

    // ------------------------------------------------------------------
    // Ratio of the smaller to the larger error, Q1.16 (up to one).
    // ------------------------------------------------------------------
    logic          rat_vld;
    logic [0:0][16:0] rat_quo;
    t_mix          rat_mix;

    hdpm_div #(
        .NL(1), .DW(40), .VW(24), .QW(17), .SW($bits(t_mix))
    ) u_ratio_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s1_vld),
        .i_num   (r_rat_num),
        .i_den   (r_rat_den),
        .i_side  (r_mix),
        .o_valid (rat_vld),
        .o_quo   (rat_quo),
        .o_side  (rat_mix)
    );

    // ------------------------------------------------------------------
    // Partial power: base times (one minus ratio).
    // ------------------------------------------------------------------
    logic [16:0]    n_pct;
    logic [BW+16:0] n_part_prod;
    logic [BW-1:0]  r_part;
    t_mix           r_p_mix;
    logic           r_p_vld;

    assign n_pct       = rat_mix.both_zero ? 17'd0 : 17'h10000 - rat_quo[0];
    assign n_part_prod = (BW+17)'(rat_mix.base) * (BW+17)'(n_pct);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (en) begin
            r_p_vld <= rat_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_part  <= n_part_prod[BW+15:16];
            r_p_mix <= rat_mix;
        end
    end

    // ------------------------------------------------------------------
    // Wheel mixing. Index 0 = LF, 1 = LB, 2 = RF, 3 = RB.
    // ------------------------------------------------------------------
    logic signed [WW-1:0] n_w [4];
    logic signed [WW-1:0] n_full, n_half, n_ang;
    logic signed [WW-1:0] r_w [4];
    logic [BW-1:0]        r_w_base;
    logic                 r_w_vld;
    logic                 same_sign;

    always_comb begin
        same_sign = (r_p_mix.x_neg == r_p_mix.y_neg) && (r_p_mix.x_zero == r_p_mix.y_zero);
        n_ang     = apply_sign(r_p_mix.ang_neg, 1'b0, MW'(r_p_mix.ang_mag));
        if (same_sign) begin
            n_full = apply_sign(r_p_mix.x_neg, r_p_mix.x_zero, MW'(r_p_mix.base));
            n_half = apply_sign(r_p_mix.x_gt_y, 1'b0, MW'(r_part));
            n_w[0] = n_full + n_ang;
            n_w[3] = n_full - n_ang;
            n_w[1] = n_half + n_ang;
            n_w[2] = n_half - n_ang;
        end else begin
            n_full = apply_sign(r_p_mix.y_neg, r_p_mix.y_zero, MW'(r_p_mix.base));
            if (r_p_mix.ax_gt_ay) begin
                n_half = apply_sign(r_p_mix.x_neg, r_p_mix.x_zero, MW'(r_part));
            end else begin
                n_half = apply_sign(r_p_mix.y_neg, r_p_mix.y_zero, MW'(r_part));
            end
            n_w[1] = n_full + n_ang;
            n_w[2] = n_full - n_ang;
            n_w[0] = n_half + n_ang;
            n_w[3] = n_half - n_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_vld <= 1'b0;
        end else if (en) begin
            r_w_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w      <= n_w;
            r_w_base <= r_p_mix.base;
        end
    end

    // ------------------------------------------------------------------
    // Magnitudes, signs and the largest magnitude.
    // ------------------------------------------------------------------
    logic [MW-1:0] n_mag [4];
    logic [3:0]    n_neg;
    logic [MW-1:0] n_max01, n_max23, n_max;
    logic [MW-1:0] r_mag [4];
    logic [3:0]    r_neg;
    logic [MW-1:0] r_max;
    logic [BW-1:0] r_m_base;
    logic          r_m_vld;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_neg[i] = r_w[i][WW-1];
            n_mag[i] = n_neg[i] ? MW'(-r_w[i]) : MW'(r_w[i]);
        end
        n_max01 = (n_mag[0] > n_mag[1]) ? n_mag[0] : n_mag[1];
        n_max23 = (n_mag[2] > n_mag[3]) ? n_mag[2] : n_mag[3];
        n_max   = (n_max01 > n_max23) ? n_max01 : n_max23;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (en) begin
            r_m_vld <= r_w_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mag    <= n_mag;
            r_neg    <= n_neg;
            r_max    <= n_max;
            r_m_base <= r_w_base;
        end
    end

    // ------------------------------------------------------------------
    // Scale down to the base power when the largest wheel exceeds it.
    // Otherwise the divider passes the magnitudes through (divisor one).
    // ------------------------------------------------------------------
    logic               over;
    logic [3:0][DN-1:0] r_dn_num;
    logic [MW-1:0]      r_dn_den;
    t_dn_side           r_dn_side;
    logic               r_dn_vld;

    assign over = r_max > MW'(r_m_base);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dn_vld <= 1'b0;
        end else if (en) begin
            r_dn_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_dn_num[i] <= over ? DN'(r_mag[i]) * DN'(r_m_base) : DN'(r_mag[i]);
            end
            r_dn_den         <= over ? r_max : MW'(1);
            r_dn_side.neg    <= r_neg;
            r_dn_side.mprime <= over ? r_m_base : r_max[BW-1:0];
        end
    end

    logic               dn_vld;
    logic [3:0][BW-1:0] dn_quo;
    t_dn_side           dn_side;

    hdpm_div #(
        .NL(4), .DW(DN), .VW(MW), .QW(BW), .SW($bits(t_dn_side))
    ) u_down_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_dn_vld),
        .i_num   (r_dn_num),
        .i_den   (r_dn_den),
        .i_side  (r_dn_side),
        .o_valid (dn_vld),
        .o_quo   (dn_quo),
        .o_side  (dn_side)
    );

    // ------------------------------------------------------------------
    // Raise to the minimum power when every wheel is below it. The final
    // integer is floor(w * min_drive / M) then; otherwise w / 65536.
    // ------------------------------------------------------------------
    logic [CW-1:0]      floor_q;
    logic               low;
    logic [3:0][UN-1:0] r_up_num;
    logic [BW-1:0]      r_up_den;
    logic [3:0]         r_up_neg;
    logic               r_up_vld;

    assign floor_q = CW'({r_cfg.min_drive, 16'd0});
    assign low     = (r_cfg.min_drive != '0) && (dn_side.mprime != '0)
                     && (CW'(dn_side.mprime) < floor_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_vld <= 1'b0;
        end else if (en) begin
            r_up_vld <= dn_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_up_num[i] <= low ? UN'(dn_quo[i]) * UN'(r_cfg.min_drive)
                                   : UN'(dn_quo[i]);
            end
            r_up_den <= low ? dn_side.mprime : BW'(32'h10000);
            r_up_neg <= dn_side.neg;
        end
    end

    logic               up_vld;
    logic [3:0][QU-1:0] up_quo;
    logic [3:0]         up_neg;

    hdpm_div #(
        .NL(4), .DW(UN), .VW(BW), .QW(QU), .SW(4)
    ) u_up_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_up_vld),
        .i_num   (r_up_num),
        .i_den   (r_up_den),
        .i_side  (r_up_neg),
        .o_valid (up_vld),
        .o_quo   (up_quo),
        .o_side  (up_neg)
    );

    // ------------------------------------------------------------------
    // Saturate to the 8-bit field, restore the sign, register the result.
    // ------------------------------------------------------------------
    logic [31:0] n_out;
    logic [31:0] r_out;
    logic [6:0]  sat;

    always_comb begin
        n_out = '0;
        for (int i = 0; i < 4; i++) begin
            sat = (up_quo[i] > QU'(OUT_MAX)) ? 7'(OUT_MAX) : up_quo[i][6:0];
            n_out[8*i +: 8] = up_neg[i] ? 8'(-{1'b0, sat}) : {1'b0, sat};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= up_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:0] != 8'h80 && m_axis_tdata[15:8] != 8'h80
                        && m_axis_tdata[23:16] != 8'h80 && m_axis_tdata[31:24] != 8'h80))
        else $error("wheel power outside -127..127");

    a_scaled_le_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dn_vld |-> (dn_quo[0] <= dn_side.mprime && dn_quo[1] <= dn_side.mprime
                 && dn_quo[2] <= dn_side.mprime && dn_quo[3] <= dn_side.mprime))
        else $error("scaled wheel exceeds the largest magnitude");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !m_axis_tready) |=> ($stable(r_out) && r_out_vld))
        else $error("output lost during stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule
`default_nettype wire
